// File: src/rpet_pkg.sv
// Shared constants and types for the ranked pairs tally block.
// No dependencies; imported by ranked_pairs_election_tally, rpet_lock and the testbench.
`timescale 1ns / 1ps
package rpet_pkg;
  localparam int MAX_CAND   = 9;
  localparam int TALLY_W    = 16;
  localparam int CIDX_W     = 4;
  localparam int PAIR_SLOTS = MAX_CAND * (MAX_CAND - 1) / 2;
  localparam int TDEPTH     = MAX_CAND * MAX_CAND;
  localparam int TADDR_W    = $clog2(TDEPTH);
  localparam int PADDR_W    = $clog2(PAIR_SLOTS + 1);

  localparam logic [1:0] ST_RANK_OK  = 2'd0;
  localparam logic [1:0] ST_BALLOT   = 2'd1;
  localparam logic [1:0] ST_DISCARD  = 2'd2;
  localparam logic [1:0] ST_WINNER   = 2'd3;

  localparam logic REG_CAND_COUNT = 1'b0;

  typedef struct packed {
    logic [CIDX_W-1:0]  w;
    logic [CIDX_W-1:0]  l;
    logic [TALLY_W-1:0] m;
  } pair_t;

  typedef struct packed {
    logic              clear;
    logic              start;
    logic              step;
    logic              lock;
    logic [CIDX_W-1:0] w;
    logic [CIDX_W-1:0] l;
  } lock_ctrl_t;

  typedef struct packed {
    logic stable;
    logic hit;
  } lock_stat_t;
endpackage

// File: src/ranked_pairs_election_tally.sv
// Ranked pairs election tally: top level with the sequencer and tally store.
// Depends on rpet_pkg, rpet_ram and rpet_lock.
//
// After reset the block sweeps the 81-entry tally memory to zero before it
// takes a transaction. The rank entry that completes a ballot then walks the
// tally memory with read-modify-write for each candidate pair. A decide reads
// every tally cell twice, then repeatedly scans the pair memory to pick the
// largest unprocessed margin and runs the reachability unit for each pick,
// then drains the winners in candidate order. The single tally memory port and
// the pair scan set the pace; one transaction at a time.
`timescale 1ns / 1ps
module ranked_pairs_election_tally (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [rpet_pkg::CIDX_W-1:0]   candidate_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [rpet_pkg::CIDX_W-1:0]   winner_index,
  output logic                          last
);
  import rpet_pkg::*;

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_ADD_ROW  = 4'd2;
  localparam logic [3:0] S_ADD_RD   = 4'd3;
  localparam logic [3:0] S_ADD_WR   = 4'd4;
  localparam logic [3:0] S_FORM_RD1 = 4'd5;
  localparam logic [3:0] S_FORM_RD2 = 4'd6;
  localparam logic [3:0] S_FORM_CMP = 4'd7;
  localparam logic [3:0] S_PICK_RD  = 4'd8;
  localparam logic [3:0] S_PICK_EV  = 4'd9;
  localparam logic [3:0] S_PICK_END = 4'd10;
  localparam logic [3:0] S_REACH    = 4'd11;
  localparam logic [3:0] S_EMIT     = 4'd12;

  logic [3:0]          state;
  logic [CIDX_W-1:0]   cand_count;
  logic [CIDX_W-1:0]   n;
  logic [CIDX_W-1:0]   rank_position;
  logic [CIDX_W-1:0]   ballot_ranks [MAX_CAND];
  logic [CIDX_W-1:0]   ci, cj;
  logic [MAX_CAND-1:0] seen;
  logic [TADDR_W-1:0]  clr;
  logic [TALLY_W-1:0]  ta;
  logic [PADDR_W-1:0]  pair_total, pk, best;
  logic [PAIR_SLOTS-1:0] done;
  logic                found;
  logic [TALLY_W-1:0]  bestm;
  logic [CIDX_W-1:0]   bw, bl;

  logic                t_we;
  logic [TADDR_W-1:0]  t_waddr, t_raddr, addr_wj, addr_ij, addr_ji;
  logic [TALLY_W-1:0]  t_wdata, t_rdata;
  logic                p_we;
  pair_t               p_wdata, p_rdata;
  logic [CIDX_W-1:0]   w;
  lock_ctrl_t          lctl;
  lock_stat_t          lstat;
  logic [MAX_CAND-1:0] incoming;
  logic                in_acc, out_acc, cfg_wr, later, j_end, i_end, emit;

  assign pready = 1'b1;
  assign prdata = {{(32-CIDX_W){1'b0}}, cand_count};
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAND_COUNT);
  assign n = (cand_count == '0) ? CIDX_W'(1) :
             (cand_count > CIDX_W'(MAX_CAND)) ? CIDX_W'(MAX_CAND) : cand_count;

  assign in_stall = (state != S_IDLE) || out_valid;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign emit     = (state == S_EMIT) && (ci < n) && !incoming[ci] &&
                    (!out_valid || out_acc);

  assign w       = ballot_ranks[ci];
  assign addr_wj = TADDR_W'(w) * TADDR_W'(MAX_CAND) + TADDR_W'(cj);
  assign addr_ij = TADDR_W'(ci) * TADDR_W'(MAX_CAND) + TADDR_W'(cj);
  assign addr_ji = TADDR_W'(cj) * TADDR_W'(MAX_CAND) + TADDR_W'(ci);
  assign j_end   = (cj == n - CIDX_W'(1));
  assign i_end   = (ci == n - CIDX_W'(1));

  always_comb begin
    t_we    = 1'b0;
    t_waddr = addr_wj;
    t_wdata = (t_rdata == '1) ? t_rdata : t_rdata + TALLY_W'(1);
    case (state)
      S_CLR: begin
        t_we    = 1'b1;
        t_waddr = clr;
        t_wdata = '0;
      end
      S_ADD_WR: t_we = 1'b1;
      default: ;
    endcase
    case (state)
      S_FORM_RD1: t_raddr = addr_ij;
      S_FORM_RD2: t_raddr = addr_ji;
      default:    t_raddr = addr_wj;
    endcase
  end

  assign p_we      = (state == S_FORM_CMP) && (ta > t_rdata) &&
                     (pair_total < PADDR_W'(PAIR_SLOTS));
  assign p_wdata.w = ci;
  assign p_wdata.l = cj;
  assign p_wdata.m = ta - t_rdata;

  always_comb begin
    lctl.clear = in_acc && action;
    lctl.start = (state == S_PICK_END) && found;
    lctl.step  = (state == S_REACH) && !lstat.stable;
    lctl.lock  = (state == S_REACH) && lstat.stable && !lstat.hit;
    lctl.w     = bw;
    lctl.l     = bl;
  end

  always_comb begin
    later = 1'b0;
    for (int k = 0; k < MAX_CAND; k++) begin
      if (CIDX_W'(k) > ci && CIDX_W'(k) < n && !incoming[k]) later = 1'b1;
    end
  end

  rpet_ram #(.DEPTH(TDEPTH), .WIDTH(TALLY_W), .AW(TADDR_W)) u_tally (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  rpet_ram #(.DEPTH(PAIR_SLOTS), .WIDTH($bits(pair_t)), .AW(PADDR_W)) u_pairs (
    .clk(clk), .we(p_we), .waddr(pair_total), .wdata(p_wdata),
    .raddr(pk), .rdata(p_rdata)
  );

  rpet_lock u_lock (
    .clk(clk), .rst(rst), .ctrl(lctl), .stat(lstat), .incoming(incoming)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      cand_count    <= CIDX_W'(MAX_CAND);
      rank_position <= '0;
      clr           <= '0;
      out_valid     <= 1'b0;
      pair_total    <= '0;
    end else begin
      if (cfg_wr) begin
        cand_count    <= pwdata[CIDX_W-1:0];
        rank_position <= '0;
      end
      if (out_acc && !emit) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr <= clr + TADDR_W'(1);
          if (clr == TADDR_W'(TDEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            ci <= '0;
            cj <= '0;
            if (action) begin
              pair_total <= '0;
              state      <= S_FORM_RD1;
            end else begin
              out_valid    <= 1'b1;
              winner_index <= '0;
              last         <= 1'b1;
              if (candidate_index >= n || rank_position >= n) begin
                rank_position <= '0;
                status        <= ST_DISCARD;
              end else begin
                ballot_ranks[rank_position] <= candidate_index;
                if (rank_position + CIDX_W'(1) >= n) begin
                  rank_position <= '0;
                  status        <= ST_BALLOT;
                  seen          <= '0;
                  state         <= S_ADD_ROW;
                end else begin
                  rank_position <= rank_position + CIDX_W'(1);
                  status        <= ST_RANK_OK;
                end
              end
            end
          end
        end
        S_ADD_ROW: begin
          seen  <= seen | (MAX_CAND'(1) << w);
          cj    <= '0;
          state <= S_ADD_RD;
        end
        S_ADD_RD, S_ADD_WR: begin
          if (state == S_ADD_RD && !seen[cj]) begin
            state <= S_ADD_WR;
          end else if (j_end) begin
            ci    <= ci + CIDX_W'(1);
            state <= i_end ? S_IDLE : S_ADD_ROW;
          end else begin
            cj    <= cj + CIDX_W'(1);
            state <= S_ADD_RD;
          end
        end
        S_FORM_RD1: state <= S_FORM_RD2;
        S_FORM_RD2: begin
          ta    <= t_rdata;
          state <= S_FORM_CMP;
        end
        S_FORM_CMP: begin
          if (p_we) pair_total <= pair_total + PADDR_W'(1);
          state <= S_FORM_RD1;
          if (j_end) begin
            cj <= '0;
            ci <= ci + CIDX_W'(1);
            if (i_end) begin
              done  <= '0;
              pk    <= '0;
              found <= 1'b0;
              state <= S_PICK_RD;
            end
          end else begin
            cj <= cj + CIDX_W'(1);
          end
        end
        S_PICK_RD: state <= (pk == pair_total) ? S_PICK_END : S_PICK_EV;
        S_PICK_EV: begin
          // strict compare keeps the earliest pair among equal margins
          if (!done[pk] && (!found || p_rdata.m > bestm)) begin
            found <= 1'b1;
            best  <= pk;
            bestm <= p_rdata.m;
            bw    <= p_rdata.w;
            bl    <= p_rdata.l;
          end
          pk    <= pk + PADDR_W'(1);
          state <= S_PICK_RD;
        end
        S_PICK_END: begin
          if (found) begin
            done[best] <= 1'b1;
            state      <= S_REACH;
          end else begin
            ci    <= '0;
            state <= S_EMIT;
          end
        end
        S_REACH: begin
          if (lstat.stable) begin
            pk    <= '0;
            found <= 1'b0;
            state <= S_PICK_RD;
          end
        end
        S_EMIT: begin
          if (ci >= n) begin
            state <= S_IDLE;
          end else if (incoming[ci]) begin
            ci <= ci + CIDX_W'(1);
          end else if (emit) begin
            out_valid    <= 1'b1;
            status       <= ST_WINNER;
            winner_index <= ci;
            last         <= !later;
            ci           <= ci + CIDX_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_in_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> state == S_IDLE)
    else $error("input taken while busy");
  a_pair_bound: assert property (@(posedge clk) disable iff (rst)
    pair_total <= PADDR_W'(PAIR_SLOTS))
    else $error("pair count overflow");
  a_emit_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && state == S_EMIT) |-> status == ST_WINNER)
    else $error("non-winner result during winner drain");
endmodule

// File: src/rpet_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rpet_ram #(
  parameter int DEPTH = 81,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/rpet_lock.sv
// Locked-edge graph and the reachability unit used to reject cycles.
// Depends on rpet_pkg.
`timescale 1ns / 1ps
module rpet_lock (
  input  logic                                clk,
  input  logic                                rst,
  input  rpet_pkg::lock_ctrl_t                ctrl,
  output rpet_pkg::lock_stat_t                stat,
  output logic [rpet_pkg::MAX_CAND-1:0]       incoming
);
  import rpet_pkg::*;

  logic [MAX_CAND-1:0] locked [MAX_CAND];
  logic [MAX_CAND-1:0] reach;
  logic [MAX_CAND-1:0] spread;

  always_comb begin
    spread   = reach;
    incoming = '0;
    for (int v = 0; v < MAX_CAND; v++) begin
      if (reach[v]) spread = spread | locked[v];
      incoming = incoming | locked[v];
    end
    stat.stable = (spread == reach);
    stat.hit    = reach[ctrl.w];
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int v = 0; v < MAX_CAND; v++) locked[v] <= '0;
    end else if (ctrl.lock) begin
      locked[ctrl.w][ctrl.l] <= 1'b1;
    end
    if (ctrl.start) begin
      reach <= MAX_CAND'(1) << ctrl.l;
    end else if (ctrl.step) begin
      reach <= spread;
    end
  end
endmodule

// File: verif/tb_ranked_pairs_election_tally.sv
// Self-checking testbench for the ranked pairs election tally block.
// It predicts every result from its own tally model, drives both handshakes and checks every result.
// Depends on rpet_pkg and ranked_pairs_election_tally.
`timescale 1ns / 1ps
module tb_ranked_pairs_election_tally;
  import rpet_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TALLY_TOP   = (1 << TALLY_W) - 1;

  typedef struct {
    logic [1:0]        st;
    logic [CIDX_W-1:0] win;
    logic              lst;
  } tally_result_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall, action;
  logic [CIDX_W-1:0] candidate_index;
  logic out_valid, out_stall;
  logic [1:0] status;
  logic [CIDX_W-1:0] winner_index;
  logic last;

  ranked_pairs_election_tally dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .action(action),
    .candidate_index(candidate_index), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .winner_index(winner_index),
    .last(last)
  );

  // tally model state
  logic [TALLY_W-1:0] tally [MAX_CAND][MAX_CAND];
  logic [CIDX_W-1:0]  ballot [MAX_CAND];
  int unsigned        rank_pos;
  logic [3:0]         cand_reg;
  logic [MAX_CAND-1:0] lock_row [MAX_CAND];

  tally_result_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int burst_left;
  int hold_left;
  int hold_requests;
  int hold_served;
  int stretch_left, stall_mode;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic int unsigned active_count();
    int unsigned n;
    n = {28'd0, cand_reg};
    if (n < 1) n = 1;
    if (n > MAX_CAND) n = MAX_CAND;
    return n;
  endfunction

  function automatic void push_result(logic [1:0] st, int win, logic lst);
    tally_result_t r;
    r.st = st;
    r.win = CIDX_W'(win);
    r.lst = lst;
    expected_results.push_back(r);
  endfunction

  function automatic logic [31:0] pair_margin(int w, int l);
    return 32'(tally[w][l]) - 32'(tally[l][w]);
  endfunction

  function automatic bit path_exists(int from, int to, int n);
    logic [MAX_CAND-1:0] reach, prev;
    reach = '0;
    reach[from] = 1'b1;
    prev = '0;
    while (reach != prev) begin
      prev = reach;
      for (int v = 0; v < n; v++)
        if (reach[v]) reach |= lock_row[v];
    end
    return reach[to];
  endfunction

  function automatic void predict_decide();
    int pw[PAIR_SLOTS], pl[PAIR_SLOTS];
    int total, n, t, k, last_k;
    logic [MAX_CAND-1:0] incoming;
    n = active_count();
    total = 0;
    for (int i = 0; i < MAX_CAND; i++) lock_row[i] = '0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (tally[i][j] > tally[j][i] && total < PAIR_SLOTS) begin
          pw[total] = i;
          pl[total] = j;
          total++;
        end
    // stable bubble sort, largest margin first
    for (int i = 0; i + 1 < total; i++)
      for (int j = 0; j + 1 < total - i; j++)
        if (pair_margin(pw[j], pl[j]) < pair_margin(pw[j+1], pl[j+1])) begin
          t = pw[j]; pw[j] = pw[j+1]; pw[j+1] = t;
          t = pl[j]; pl[j] = pl[j+1]; pl[j+1] = t;
        end
    for (int i = 0; i < total; i++)
      if (!path_exists(pl[i], pw[i], n)) lock_row[pw[i]][pl[i]] = 1'b1;
    incoming = '0;
    for (int i = 0; i < n; i++) incoming |= lock_row[i];
    k = 0;
    last_k = -1;
    for (int i = 0; i < n; i++)
      if (!incoming[i]) begin
        push_result(ST_WINNER, i, 1'b0);
        last_k = expected_results.size() - 1;
        k++;
      end
    if (last_k >= 0) expected_results[last_k].lst = 1'b1;
  endfunction

  function automatic void predict_rank(logic [CIDX_W-1:0] idx);
    int unsigned n;
    logic [MAX_CAND-1:0] seen;
    int w;
    n = active_count();
    if (idx >= n || rank_pos >= n) begin
      rank_pos = 0;
      push_result(ST_DISCARD, 0, 1'b1);
      return;
    end
    ballot[rank_pos] = idx;
    rank_pos++;
    if (rank_pos >= n) begin
      seen = '0;
      for (int i = 0; i < n; i++) begin
        w = int'(ballot[i]);
        seen[w] = 1'b1;
        for (int j = 0; j < n; j++)
          if (!seen[j] && tally[w][j] < TALLY_TOP) tally[w][j]++;
      end
      rank_pos = 0;
      push_result(ST_BALLOT, 0, 1'b1);
    end else begin
      push_result(ST_RANK_OK, 0, 1'b1);
    end
  endfunction

  // Leaves in_valid high on return so a following transaction needs no re-raise.
  task automatic send_item(input logic act, input int idx);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    action <= act;
    candidate_index <= CIDX_W'(idx);
    do @(posedge clk); while (in_stall);
    if (act) predict_decide();
    else predict_rank(CIDX_W'(idx));
  endtask

  // Wait until every result is back and the block is idle again.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0 || in_stall) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(input logic [3:0] value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(4 * REG_CAND_COUNT);
    pwdata <= {16'($urandom_range(0, 65535)), 12'($urandom_range(0, 4095)), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cand_reg = value;
    rank_pos = 0;
    @(posedge clk);
  endtask

  // Mostly a permutation; sometimes repeats or a bad entry part way through.
  task automatic send_ballot();
    int unsigned n;
    int perm[MAX_CAND];
    int j, t;
    n = active_count();
    for (int i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i]; perm[i] = perm[j]; perm[j] = t;
    end
    case ($urandom_range(0, 9))
      0: for (int i = 0; i < n; i++) send_item(1'b0, $urandom_range(0, n - 1));
      1: begin
        for (int i = 0; i < $urandom_range(0, n - 1); i++) send_item(1'b0, perm[i]);
        send_item(1'b0, $urandom_range(n, 15));
      end
      default: for (int i = 0; i < n; i++) send_item(1'b0, perm[i]);
    endcase
  endtask

  task automatic test_directed();
    send_item(1'b1, 0);
    for (int i = 0; i < 9; i++) send_item(1'b0, i);
    send_item(1'b1, 15);
    send_item(1'b0, 8);
    send_item(1'b0, 9);
    send_item(1'b0, 15);
    send_item(1'b0, 3);
    send_item(1'b0, 3);
    send_item(1'b1, 0);
  endtask

  task automatic test_count_extremes();
    write_count(4'd1);
    send_item(1'b0, 0);
    send_item(1'b0, 1);
    send_item(1'b1, 0);
    write_count(4'd0);
    send_item(1'b0, 0);
    send_item(1'b1, 0);
    write_count(4'd15);
    send_item(1'b0, 2);
    send_item(1'b0, 5);
    write_count(4'd2);
    send_item(1'b0, 1);
    send_item(1'b0, 0);
    send_item(1'b1, 0);
  endtask

  task automatic test_random_ballots(input int items);
    logic [3:0] counts[5] = '{4'd3, 4'd9, 4'd5, 4'd4, 4'd9};
    for (int phase = 0; phase < 5; phase++) begin
      write_count(counts[phase]);
      for (int b = 0; b < items / 5; b += active_count()) begin
        if ($urandom_range(0, 6) == 0) send_item(1'b0, $urandom_range(0, 15));
        send_ballot();
        if ($urandom_range(0, 3) == 0) send_item(1'b1, $urandom_range(0, 15));
      end
      send_item(1'b1, $urandom_range(0, 15));
    end
  endtask

  task automatic test_backpressure();
    write_count(4'd2);
    hold_requests++;
    burst_left = 40;
    for (int i = 0; i < 12; i++) send_item(1'b0, $urandom_range(0, 1));
    send_item(1'b1, 0);
    drain();
    send_item(1'b0, 1);
    send_item(1'b0, 0);
    send_item(1'b1, 0);
  endtask

  // result checker
  always @(posedge clk) begin
    tally_result_t exp_r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d", status));
        end else begin
          exp_r = expected_results.pop_front();
          if (status !== exp_r.st)
            report_mismatch($sformatf("status %0d, want %0d", status, exp_r.st));
          if (winner_index !== exp_r.win)
            report_mismatch($sformatf("winner %0d, want %0d", winner_index, exp_r.win));
          if (last !== exp_r.lst)
            report_mismatch($sformatf("last %0b, want %0b", last, exp_r.lst));
        end
      end
    end
  end

  // receiver stall pattern, with a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_served = 0;
      stretch_left = 0;
      stall_mode = 0;
    end else begin
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (stretch_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          stretch_left = $urandom_range(5, 60);
        end
        stretch_left--;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          default: out_stall <= cycles[0];
        endcase
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    action = 1'b0;
    candidate_index = '0;
    burst_left = 0;
    hold_requests = 0;
    rank_pos = 0;
    cand_reg = 4'd9;
    for (int i = 0; i < MAX_CAND; i++) begin
      lock_row[i] = '0;
      ballot[i] = '0;
      for (int j = 0; j < MAX_CAND; j++) tally[i][j] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // hold off while the tally memory clears
    repeat (100) @(posedge clk);
    test_directed();
    test_count_extremes();
    test_random_ballots(80);
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
